/* sv/entity_table_nearest_search_macros.svh */
// Assertion macros used by entity_table_nearest_search.sv.
`ifndef ENTITY_TABLE_NEAREST_SEARCH_MACROS_SVH
`define ENTITY_TABLE_NEAREST_SEARCH_MACROS_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define ETNS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert that an antecedent implies a consequent in the following cycle.
`define ETNS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/etns_pkg.sv */
`default_nettype none
package etns_pkg;
  localparam logic [2:0] ACT_REG   = 3'd0;
  localparam logic [2:0] ACT_DEREG = 3'd1;
  localparam logic [2:0] ACT_SETP  = 3'd2;
  localparam logic [2:0] ACT_SETT  = 3'd3;
  localparam logic [2:0] ACT_CLOSE = 3'd4;
  localparam logic [2:0] ACT_GETP  = 3'd5;
  localparam logic [2:0] ACT_CHKP  = 3'd6;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NONE      = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] entry_id;
    logic [7:0]  team_in;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } cmd_t;

  typedef struct packed {
    logic [15:0] result_id;
    logic [15:0] result_x;
    logic [15:0] result_y;
    logic [1:0]  status;
  } res_t;
endpackage
`default_nettype wire

/* sv/etns_front.sv */
`default_nettype none
// Input side: takes transactions into a two-entry command queue.
module etns_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire etns_pkg::cmd_t in_cmd,
  output logic                q_valid,
  input  wire                 q_ready,
  output etns_pkg::cmd_t      q_cmd
);
  etns_pkg::cmd_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_cmd;
  end
endmodule
`default_nettype wire

/* sv/etns_back.sv */
`default_nettype none
// Execution side: scans the slot table one slot per cycle, then applies
// any write and presents the result in an output register.
module etns_back #(
  parameter int SLOTS   = 64,
  parameter int ID_BITS = 16
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_valid,
  output logic                q_ready,
  input  wire etns_pkg::cmd_t q_cmd,
  output logic                res_valid,
  input  wire                 res_ready,
  output etns_pkg::res_t      res
);
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_FIN = 2'd2, S_OUT = 2'd3;

  // Slot payload memory: id, team, x, y.
  logic [ID_BITS+40-1:0] mem [SLOTS];
  logic [SLOTS-1:0]      valid_r;
  logic [ID_BITS-1:0]    next_id_r;

  logic [1:0]         st_r;
  etns_pkg::cmd_t     cmd_r;
  logic [SW:0]        idx_r;   // read address issued
  logic [SW-1:0]      didx_r;  // slot of the data now registered
  logic               dval_r;
  logic [ID_BITS+40-1:0] rd_r;
  logic [ID_BITS+40-1:0] brd_r;  // payload of the best slot so far
  logic               have_r;
  logic [16:0]        best_r;
  logic [ID_BITS-1:0] bid_r;
  logic [SW-1:0]      bslot_r;
  logic               free_have_r;
  logic [SW-1:0]      free_r;
  etns_pkg::res_t     res_r;

  logic [ID_BITS-1:0] r_id;
  logic [7:0]         r_team;
  logic signed [15:0] r_x, r_y;
  logic signed [16:0] dx, dy;
  logic [16:0]        ax, ay, mdist;
  logic               live, cand, better;

  assign {r_id, r_team, r_x, r_y} = rd_r;
  assign live = dval_r && valid_r[didx_r];
  assign dx = $signed({r_x[15], r_x}) - $signed({cmd_r.pos_x[15], cmd_r.pos_x});
  assign dy = $signed({r_y[15], r_y}) - $signed({cmd_r.pos_y[15], cmd_r.pos_y});
  assign ax = dx[16] ? 17'(-dx) : 17'(dx);
  assign ay = dy[16] ? 17'(-dy) : 17'(dy);
  assign mdist = ax + ay;

  always_comb begin
    cand = 1'b0;
    better = 1'b0;
    case (cmd_r.action)
      etns_pkg::ACT_CLOSE: begin
        cand = live && (r_team != cmd_r.team_in);
        better = !have_r || mdist < best_r || (mdist == best_r && r_id < bid_r);
      end
      etns_pkg::ACT_CHKP: begin
        cand = live && r_x == cmd_r.pos_x && r_y == cmd_r.pos_y;
        better = !have_r || r_id < bid_r;
      end
      etns_pkg::ACT_DEREG, etns_pkg::ACT_SETP, etns_pkg::ACT_SETT,
      etns_pkg::ACT_GETP: begin
        cand = live && cmd_r.entry_id != 16'd0 && 32'(r_id) == 32'(cmd_r.entry_id);
        better = !have_r;
      end
      default: begin
        cand = 1'b0;
        better = 1'b0;
      end
    endcase
  end

  assign q_ready   = (st_r == S_IDLE);
  assign res_valid = (st_r == S_OUT);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (st_r == S_SCAN && idx_r < (SW+1)'(SLOTS)) rd_r <= mem[idx_r[SW-1:0]];
    if (st_r == S_FIN && have_r) begin
      case (cmd_r.action)
        etns_pkg::ACT_SETP:
          mem[bslot_r] <= {brd_r[ID_BITS+39:32], cmd_r.pos_x, cmd_r.pos_y};
        etns_pkg::ACT_SETT:
          mem[bslot_r] <= {bid_r, cmd_r.team_in, brd_r[31:0]};
        default: ;
      endcase
    end
    if (st_r == S_FIN && cmd_r.action == etns_pkg::ACT_REG && free_have_r &&
        next_id_r != '1)
      mem[free_r] <= {ID_BITS'(next_id_r + 1'b1), 40'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      valid_r <= '0;
      next_id_r <= '0;
      dval_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r <= q_cmd;
            idx_r <= '0;
            dval_r <= 1'b0;
            have_r <= 1'b0;
            free_have_r <= 1'b0;
            st_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          dval_r <= idx_r < (SW+1)'(SLOTS);
          didx_r <= idx_r[SW-1:0];
          idx_r <= idx_r + 1'b1;
          if (dval_r && !valid_r[didx_r] && !free_have_r) begin
            free_have_r <= 1'b1;
            free_r <= didx_r;
          end
          if (cand && better) begin
            have_r <= 1'b1;
            best_r <= mdist;
            bid_r <= r_id;
            bslot_r <= didx_r;
            brd_r <= rd_r;
          end
          if (!(idx_r < (SW+1)'(SLOTS)) && !dval_r) st_r <= S_FIN;
        end
        S_FIN: begin
          res_r.result_id <= 16'd0;
          res_r.result_x <= 16'd0;
          res_r.result_y <= 16'd0;
          res_r.status <= etns_pkg::ST_NONE;
          case (cmd_r.action)
            etns_pkg::ACT_REG: begin
              if (!free_have_r) res_r.status <= etns_pkg::ST_FULL;
              else if (next_id_r == '1) res_r.status <= etns_pkg::ST_EXHAUSTED;
              else begin
                next_id_r <= next_id_r + 1'b1;
                valid_r[free_r] <= 1'b1;
                res_r.result_id <= 16'(next_id_r + 1'b1);
                res_r.status <= etns_pkg::ST_OK;
              end
            end
            etns_pkg::ACT_DEREG, etns_pkg::ACT_SETP, etns_pkg::ACT_SETT: begin
              if (have_r) begin
                if (cmd_r.action == etns_pkg::ACT_DEREG) valid_r[bslot_r] <= 1'b0;
                res_r.result_id <= cmd_r.entry_id;
                res_r.status <= etns_pkg::ST_OK;
              end
            end
            etns_pkg::ACT_GETP: begin
              if (have_r) begin
                res_r.result_id <= cmd_r.entry_id;
                res_r.result_x <= brd_r[31:16];
                res_r.result_y <= brd_r[15:0];
                res_r.status <= etns_pkg::ST_OK;
              end
            end
            etns_pkg::ACT_CLOSE, etns_pkg::ACT_CHKP: begin
              if (have_r) begin
                res_r.result_id <= 16'(bid_r);
                res_r.status <= etns_pkg::ST_OK;
              end
            end
            default: ;
          endcase
          st_r <= S_OUT;
        end
        S_OUT: if (res_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* sv/entity_table_nearest_search.sv */
// The back end handles one transaction at a time and takes the next only after
// its result is taken; the slot memory is read one slot per cycle through
// its single read port.
// A two-entry queue takes input while the scan runs.
// Synchronous active-low reset empties the table and the id counter.
`default_nettype none
`include "entity_table_nearest_search_macros.svh"
module entity_table_nearest_search #(
  parameter int SLOTS   = 64,
  parameter int ID_BITS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // action[2:0], entry_id[18:3], team_in[26:19], pos_x[42:27], pos_y[58:43]
  input  wire  [63:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // result_id[15:0], result_x[31:16], result_y[47:32], status[49:48]
  output logic [55:0] out_tdata
);
  etns_pkg::cmd_t in_cmd, q_cmd;
  etns_pkg::res_t res;
  logic q_valid, q_ready;

  assign in_cmd.action   = in_tdata[2:0];
  assign in_cmd.entry_id = in_tdata[18:3];
  assign in_cmd.team_in  = in_tdata[26:19];
  assign in_cmd.pos_x    = in_tdata[42:27];
  assign in_cmd.pos_y    = in_tdata[58:43];

  etns_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  etns_back #(.SLOTS(SLOTS), .ID_BITS(ID_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd,
    .res_valid(out_tvalid), .res_ready(out_tready), .res
  );

  assign out_tdata = {6'd0, res.status, res.result_y, res.result_x, res.result_id};

  `ETNS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ETNS_ASSERT_IMP(a_ok_nonzero, clk, rst_n, out_tvalid && res.status == etns_pkg::ST_OK && (u_back.cmd_r.action != etns_pkg::ACT_GETP), res.result_id != 16'd0)
endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

  localparam int NSLOTS = 64;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct {
    logic [15:0] rid;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [1:0]  st;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;

  entity_table_nearest_search DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Shadow copy of the entity table.
  bit          tab_live[NSLOTS];
  logic [15:0] tab_id[NSLOTS];
  logic [7:0]  tab_team[NSLOTS];
  logic signed [15:0] tab_x[NSLOTS];
  logic signed [15:0] tab_y[NSLOTS];
  logic [15:0] last_id;

  answer_t pending_answers[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int received = 0;
  bit idle_on = 1;
  int act_seen[8];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic answer_t predict_entity_op(logic [2:0] act, logic [15:0] eid,
                                                logic [7:0] team,
                                                logic signed [15:0] qx,
                                                logic signed [15:0] qy);
    answer_t a;
    int s;
    bit have;
    logic [17:0] d, best;
    a.rid = 0; a.rx = 0; a.ry = 0; a.st = etns_pkg::ST_NONE;
    s = -1;
    have = 0;
    best = 0;
    case (act)
      etns_pkg::ACT_REG: begin
        for (int i = 0; i < NSLOTS; i++)
          if (!tab_live[i] && s < 0) s = i;
        if (s < 0) a.st = etns_pkg::ST_FULL;
        else if (last_id == 16'hFFFF) a.st = etns_pkg::ST_EXHAUSTED;
        else begin
          last_id++;
          tab_live[s] = 1; tab_id[s] = last_id; tab_team[s] = 0;
          tab_x[s] = 0; tab_y[s] = 0;
          a.rid = last_id; a.st = etns_pkg::ST_OK;
        end
      end
      etns_pkg::ACT_DEREG, etns_pkg::ACT_SETP, etns_pkg::ACT_SETT,
      etns_pkg::ACT_GETP: begin
        if (eid != 0)
          for (int i = 0; i < NSLOTS; i++)
            if (tab_live[i] && tab_id[i] == eid && s < 0) s = i;
        if (s >= 0) begin
          if (act == etns_pkg::ACT_DEREG) tab_live[s] = 0;
          else if (act == etns_pkg::ACT_SETP) begin tab_x[s] = qx; tab_y[s] = qy; end
          else if (act == etns_pkg::ACT_SETT) tab_team[s] = team;
          else begin a.rx = tab_x[s]; a.ry = tab_y[s]; end
          a.rid = eid; a.st = etns_pkg::ST_OK;
        end
      end
      etns_pkg::ACT_CLOSE: begin
        for (int i = 0; i < NSLOTS; i++) begin
          if (tab_live[i] && tab_team[i] != team) begin
            d = 18'(($signed(17'(tab_x[i])) >= $signed(17'(qx))) ?
                    17'(tab_x[i]) - 17'(qx) : 17'(qx) - 17'(tab_x[i]))
              + 18'(($signed(17'(tab_y[i])) >= $signed(17'(qy))) ?
                    17'(tab_y[i]) - 17'(qy) : 17'(qy) - 17'(tab_y[i]));
            if (!have || d < best || (d == best && tab_id[i] < a.rid)) begin
              have = 1; best = d; a.rid = tab_id[i];
            end
          end
        end
        a.st = have ? etns_pkg::ST_OK : etns_pkg::ST_NONE;
      end
      etns_pkg::ACT_CHKP: begin
        for (int i = 0; i < NSLOTS; i++)
          if (tab_live[i] && tab_x[i] == qx && tab_y[i] == qy &&
              (!have || tab_id[i] < a.rid)) begin
            have = 1; a.rid = tab_id[i];
          end
        a.st = have ? etns_pkg::ST_OK : etns_pkg::ST_NONE;
      end
      default: ;
    endcase
    return a;
  endfunction

  // Valid stays high between back-to-back transactions and drops only while idling.
  task automatic send_entity_op(logic [2:0] act, logic [15:0] eid, logic [7:0] team,
                                logic [15:0] qx, logic [15:0] qy);
    while (idle_on && $urandom_range(99) < 20) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tdata  <= {5'd0, qy, qx, team, eid, act};
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_answers.push_back(predict_entity_op(act, eid, team, qx, qy));
    act_seen[act]++;
    sent++;
    @(negedge clk);
  endtask

  // Result checker; out_tready is redrawn at each falling edge.
  always @(negedge clk) begin
    if (rst_n) out_tready <= idle_on ? ($urandom_range(99) >= 20) : 1'b1;
  end

  always @(posedge clk) begin
    answer_t a;
    if (rst_n && out_tvalid && out_tready) begin
      received++;
      if (pending_answers.size() == 0) begin
        $error("unexpected transaction %h", out_tdata);
        errors++;
      end else begin
        a = pending_answers.pop_front();
        if (out_tdata[15:0] !== a.rid) begin
          $error("result_id expected %0d got %0d", a.rid, out_tdata[15:0]); errors++;
        end
        if (out_tdata[31:16] !== a.rx) begin
          $error("result_x expected %0d got %0d", $signed(a.rx),
                 $signed(out_tdata[31:16])); errors++;
        end
        if (out_tdata[47:32] !== a.ry) begin
          $error("result_y expected %0d got %0d", $signed(a.ry),
                 $signed(out_tdata[47:32])); errors++;
        end
        if (out_tdata[49:48] !== a.st) begin
          $error("status expected %0d got %0d", a.st, out_tdata[49:48]); errors++;
        end
      end
    end
  end

  task automatic drain_results();
    in_tvalid <= 0;
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_live_id();
    int i = $urandom_range(NSLOTS - 1);
    if (tab_live[i]) return tab_id[i];
    return 16'($urandom_range(last_id + 2));
  endfunction

  function automatic logic [15:0] near_coord();
    return 16'($signed($urandom_range(40)) - 20);
  endfunction

  task automatic test_directed();
    send_entity_op(etns_pkg::ACT_CLOSE, 0, 0, 0, 0);           // empty table
    send_entity_op(etns_pkg::ACT_CHKP, 0, 0, 0, 0);
    send_entity_op(etns_pkg::ACT_REG, 0, 0, 0, 0);
    send_entity_op(etns_pkg::ACT_REG, 0, 0, 0, 0);
    send_entity_op(etns_pkg::ACT_REG, 0, 0, 0, 0);
    send_entity_op(etns_pkg::ACT_SETP, 1, 0, 16'h8000, 16'h8000);
    send_entity_op(etns_pkg::ACT_SETP, 2, 0, 16'h7FFF, 16'h7FFF);
    send_entity_op(etns_pkg::ACT_SETT, 2, 8'hFF, 0, 0);
    send_entity_op(etns_pkg::ACT_SETT, 1, 8'h5A, 0, 0);
    send_entity_op(etns_pkg::ACT_GETP, 1, 0, 0, 0);
    send_entity_op(etns_pkg::ACT_GETP, 2, 0, 0, 0);
    // Largest distance across the whole plane, and a query at the origin.
    send_entity_op(etns_pkg::ACT_CLOSE, 0, 8'hFF, 16'h7FFF, 16'h7FFF);
    send_entity_op(etns_pkg::ACT_CLOSE, 0, 8'h01, 0, 0);
    send_entity_op(etns_pkg::ACT_CHKP, 0, 0, 16'h8000, 16'h8000);
    send_entity_op(etns_pkg::ACT_CHKP, 0, 0, 1, 1);
    send_entity_op(etns_pkg::ACT_GETP, 0, 0, 0, 0);            // id zero names nothing
    send_entity_op(etns_pkg::ACT_DEREG, 16'hFFFF, 0, 0, 0);
    send_entity_op(etns_pkg::ACT_DEREG, 3, 0, 0, 0);
    send_entity_op(etns_pkg::ACT_SETT, 3, 8'hAA, 0, 0);
    send_entity_op(3'd7, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_entity_op(etns_pkg::ACT_CLOSE, 0, 0, 16'h8000, 16'h7FFF);
  endtask

  task automatic test_table_full();
    for (int i = 0; i < NSLOTS + 2; i++) send_entity_op(etns_pkg::ACT_REG, 0, 0, 0, 0);
    for (int i = 0; i < 8; i++) send_entity_op(etns_pkg::ACT_DEREG, pick_live_id(), 0, 0, 0);
    // Sender holds off until the block has answered everything.
    drain_results();
  endtask

  task automatic test_random(int count);
    logic [2:0] act;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) idle_on = 0;
      if (n == count / 2 + 100) idle_on = 1;
      act = 3'($urandom_range(7));
      if (act == 3'd7 && $urandom_range(3) != 0) act = etns_pkg::ACT_CLOSE;
      if ($urandom_range(9) == 0)
        send_entity_op(act, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      else
        send_entity_op(act, pick_live_id(), 8'($urandom_range(3)),
                       $urandom_range(4) == 0 ? 16'($urandom) : near_coord(),
                       $urandom_range(4) == 0 ? 16'($urandom) : near_coord());
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = 0;
    out_tready = 0;
    for (int i = 0; i < NSLOTS; i++) tab_live[i] = 0;
    last_id = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    test_directed();
    test_table_full();
    test_random(600);
    drain_results();
    repeat (200) @(negedge clk);
    $display("Covered %0d transactions over all actions, full table, tie-breaks, extremes;",
             sent);
    $display("%0d results checked, closest issued %0d times.", received,
             act_seen[etns_pkg::ACT_CLOSE]);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
